/* src/kli_pkg.sv */
package kli_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int KEY_W = 32;
   localparam int CMD_W = 2;
   localparam int STS_W = 2;
   localparam int POS_W = 4;
   localparam int OCC_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK   = 2'd0,
      STS_MISS = 2'd1,
      STS_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   // Per-cycle controls broadcast to every cell of the row
   typedef struct packed {
      logic cmp_en;
      logic ins_en;
      logic del_en;
   } cell_ctl_type;

endpackage

/* src/kli_intf.sv */
interface kli_req_if;
   import kli_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic signed [KEY_W-1:0] key;

   modport source (output valid, cmd, key, input ready);
   modport sink   (input valid, cmd, key, output ready);
endinterface

interface kli_rsp_if;
   import kli_pkg::*;

   logic             valid;
   logic             ready;
   logic [STS_W-1:0] status;
   logic [POS_W-1:0] position;
   logic [OCC_W-1:0] occupancy;

   modport source (output valid, status, position, occupancy, input ready);
   modport sink   (input valid, status, position, occupancy, output ready);
endinterface

/* src/keyed_list_insert_search_delete.sv */
// Keyed list, newest first: insert at head, search first match, delete first match.
// The cells compare in the transfer cycle and register their match flags; the first-match
//   chain and the one-neighbor shift run in the execute state, and no new command is taken
//   until it retires into the result register, which waits while that register stays full.
// Reset (synchronous, active high) empties the list and clears handshakes;
//   slot contents are left as they are.
module keyed_list_insert_search_delete (
   input  logic        clock,
   input  logic        reset,
   kli_req_if.sink     req,
   kli_rsp_if.source   rsp
);
   import kli_pkg::*;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [OCC_W-1:0] occupancy_ff, occupancy_in;

   logic             accept;
   logic             finish;
   logic             full;
   logic             hit;
   logic [IDX_W-1:0] hit_idx;
   cell_ctl_type     ctl;

   // Row wiring: slots, match flags and the first-match chain
   logic [KEY_W-1:0] slot_vec [DEPTH];
   logic [DEPTH-1:0] match_vec;
   logic [DEPTH-1:0] valid_vec;
   logic [DEPTH:0]   seen_chain;

   // Take a new command only when no command is in flight
   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   // Retire when the output register is free or being drained this cycle
   assign finish    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp.ready);

   assign full = (count_ff == CNT_W'(DEPTH));
   assign hit  = seen_chain[DEPTH];

   assign ctl.cmp_en = accept;
   assign ctl.ins_en = finish && (cmd_ff == CMD_INSERT) && !full;
   assign ctl.del_en = finish && (cmd_ff == CMD_DELETE) && hit;

   assign seen_chain[0] = 1'b0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [KEY_W-1:0] prev_key;
      logic [KEY_W-1:0] next_key;

      assign valid_vec[g] = (CNT_W'(g) < count_ff);

      // Insert feeds the head from the held key; each cell takes its front neighbor
      if (g == 0) begin : g_head
         assign prev_key = key_ff;
      end else begin : g_body
         assign prev_key = slot_vec[g-1];
      end

      // Delete closes the gap from the rear neighbor; the tail keeps its own value
      if (g == DEPTH - 1) begin : g_tail
         assign next_key = slot_vec[g];
      end else begin : g_mid
         assign next_key = slot_vec[g+1];
      end

      kli_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .cell_valid (valid_vec[g]),
         .cmp_key    (req.key),
         .prev_key   (prev_key),
         .next_key   (next_key),
         .seen_in    (seen_chain[g]),
         .slot       (slot_vec[g]),
         .match      (match_vec[g]),
         .seen_out   (seen_chain[g+1])
      );
   end

   // Index of the match nearest the head
   always_comb begin
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   // Sequencer and command latch
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
               cmd_in   = cmd_type'(req.cmd);
               key_in   = req.key;
            end
         end
         S_EXEC: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result of the command in flight; hold count unless a shift happens
   always_comb begin
      count_in    = count_ff;
      status_in   = STS_OK;
      position_in = '0;
      unique case (cmd_ff)
         CMD_INSERT: begin
            if (full) begin
               status_in = STS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_SEARCH, CMD_DELETE: begin
            if (!hit) begin
               status_in = STS_MISS;
            end else begin
               position_in = POS_W'(hit_idx);
               if (cmd_ff == CMD_DELETE) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            // unused code: report current occupancy, change nothing
         end
      endcase
      occupancy_in = OCC_W'(count_in);
   end

   // Output register: load on retire, drop once the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (finish) begin
         status_ff    <= status_in;
         position_ff  <= position_in;
         occupancy_ff <= occupancy_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         cmd_ff       <= CMD_SEARCH;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            count_ff <= count_in;
         end
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = status_ff;
   assign rsp.position  = position_ff;
   assign rsp.occupancy = occupancy_ff;

   // Occupancy never runs past the row length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list count exceeds depth");

   // Only cells holding a key can flag a match
   a_match_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> ((match_vec & ~valid_vec) == '0))
      else $error("match flagged on empty cell");

   // A successful insert grows the list by exactly one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctl.ins_en |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not advance count");

   // A result appears only when a command retires
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result without command in flight");

endmodule

/* src/kli_cell.sv */
module kli_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  kli_pkg::cell_ctl_type       ctl,
   input  logic                        cell_valid,
   input  logic [kli_pkg::KEY_W-1:0]   cmp_key,
   input  logic [kli_pkg::KEY_W-1:0]   prev_key,
   input  logic [kli_pkg::KEY_W-1:0]   next_key,
   input  logic                        seen_in,
   output logic [kli_pkg::KEY_W-1:0]   slot,
   output logic                        match,
   output logic                        seen_out
);
   import kli_pkg::*;

   logic [KEY_W-1:0] slot_ff, slot_in;
   logic             match_ff, match_in;

   // first match at or ahead of this cell
   assign seen_out = seen_in | match_ff;

   always_comb begin
      slot_in = slot_ff;
      if (ctl.ins_en) begin
         slot_in = prev_key;
      end else if (ctl.del_en && seen_out) begin
         slot_in = next_key;
      end
   end

   assign match_in = ctl.cmp_en ? (cell_valid && (slot_ff == cmp_key)) : match_ff;

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign slot  = slot_ff;
   assign match = match_ff;

endmodule

/* tb/sv/tb.sv */
module tb;
   import kli_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TARGET_ITEMS = 1450;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 8;

   // Segment flavors of the random part: each one leans the command mix
   // so that the list climbs to full, empties out, or wanders in between.
   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_BALANCED
   } mix_type;

   // Scoreboard: keeps its own copy of the list, predicts the response of
   // every accepted command and compares the responses in order.
   class list_scoreboard;
      typedef struct {
         status_type       status;
         logic [POS_W-1:0] position;
         logic [OCC_W-1:0] occupancy;
      } outcome_type;

      logic [KEY_W-1:0] held[$];
      outcome_type      outcomes[$];
      int               errors;

      function int pending();
         return outcomes.size();
      endfunction

      // Apply one accepted command to the shadow list and queue its outcome.
      function void note_command(cmd_type op, logic [KEY_W-1:0] key);
         outcome_type o;
         int          hit;
         o.status = STS_OK;
         o.position = '0;
         hit = -1;
         case (op)
            CMD_INSERT: begin
               if (held.size() >= DEPTH) o.status = STS_FULL;
               else held.push_front(key);
            end
            CMD_SEARCH, CMD_DELETE: begin
               foreach (held[i])
                  if (hit < 0 && held[i] === key) hit = i;
               if (hit < 0) begin
                  o.status = STS_MISS;
               end else begin
                  o.position = POS_W'(hit);
                  if (op == CMD_DELETE) held.delete(hit);
               end
            end
            default: ;
         endcase
         o.occupancy = OCC_W'(held.size());
         outcomes.push_back(o);
      endfunction

      function void mismatch(string field, int want, int got);
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      // Compare one accepted response, field by field, with the oldest outcome.
      function void check_result(logic [STS_W-1:0] status, logic [POS_W-1:0] position,
                                 logic [OCC_W-1:0] occupancy);
         outcome_type o;
         if (outcomes.size() == 0) begin
            errors++;
            $display("%0t: response with nothing expected, actual status %0d",
                     $time, status, " position %0d occupancy %0d", position, occupancy);
            return;
         end
         o = outcomes.pop_front();
         if (status !== o.status) mismatch("status", o.status, status);
         if (position !== o.position) mismatch("position", o.position, position);
         if (occupancy !== o.occupancy) mismatch("occupancy", o.occupancy, occupancy);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   kli_req_if req_ch ();
   kli_rsp_if rsp_ch ();

   list_scoreboard sb = new;

   // Long receiver hold-offs asked by the stimulus and served by the receiver
   int hold_offs_asked = 0;
   int hold_offs_done = 0;
   int cycles = 0;

   // Keys that sit on the edges of the signed range, plus a few plain ones,
   // so that duplicates and hits come often.
   logic [KEY_W-1:0] key_pool[8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                     32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
                                     32'h5A5A_A5A5, 32'hA5A5_5A5A};

   keyed_list_insert_search_delete DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #HALF_PERIOD clock = ~clock;

   // Watchdog: end the run if it takes far longer than the slowest correct run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL keyed_list_insert_search_delete");
         $finish;
      end
   end

   // Monitor both channels at the rising edge. A response is registered only
   // after its command has transferred, so its outcome is already queued.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.status, rsp_ch.position, rsp_ch.occupancy);
         if (req_ch.valid && req_ch.ready)
            sb.note_command(cmd_type'(req_ch.cmd), req_ch.key);
      end
   end

   // Receiver: stall on a pattern that is redrawn after each random span, and
   // serve a long hold-off whenever the stimulus asks for one.
   initial begin
      int mode;
      int span;
      logic toggle;
      rsp_ch.ready = 1'b0;
      toggle = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         repeat (span) begin
            @(negedge clock);
            if (hold_offs_asked != hold_offs_done) begin
               // hold off while the sender keeps offering, so the block backs up
               hold_offs_done++;
               rsp_ch.ready <= 1'b0;
               repeat (LONG_HOLD) @(negedge clock);
            end
            toggle = ~toggle;
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= toggle;
            endcase
         end
      end
   end

   // Offer one command from the falling edge and hold it until transfer.
   task automatic directed_item(input cmd_type op, input logic [KEY_W-1:0] key);
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.cmd <= op;
      req_ch.key <= key;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Pick a random command at the falling edge, after the previous transfer
   // has reached the shadow list, so that hit keys come from what is held.
   task automatic random_item(input mix_type mix);
      int roll;
      int src;
      cmd_type op;
      logic [KEY_W-1:0] key;
      @(negedge clock);
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: op = (roll < 75) ? CMD_INSERT : (roll < 90) ? CMD_SEARCH : CMD_DELETE;
         MIX_DRAIN: op = (roll < 15) ? CMD_INSERT : (roll < 40) ? CMD_SEARCH : CMD_DELETE;
         default: op = (roll < 40) ? CMD_INSERT : (roll < 70) ? CMD_SEARCH : CMD_DELETE;
      endcase
      src = $urandom_range(0, 9);
      if (op == CMD_INSERT) src = src + 3;   // favor fresh keys on insert
      if (src < 6 && sb.held.size() > 0)
         key = sb.held[$urandom_range(0, sb.held.size() - 1)];
      else if (src < 9)
         key = key_pool[$urandom_range(0, 7)];
      else
         key = $urandom;
      req_ch.valid <= 1'b1;
      req_ch.cmd <= op;
      req_ch.key <= key;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Pause the sender until every queued outcome has been answered.
   task automatic wait_quiet();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int seg;
      int seg_len;
      int burst;
      int gap;
      bit quiet;
      bit pressed;
      mix_type mix;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_INSERT;
      req_ch.key = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: misses on an empty list, extreme keys, a duplicate,
      // first-match search, and deletes at head, tail and middle.
      directed_item(CMD_SEARCH, 32'h0000_0000);
      directed_item(CMD_DELETE, 32'h8000_0000);
      directed_item(CMD_INSERT, 32'h8000_0000);
      directed_item(CMD_INSERT, 32'h7FFF_FFFF);
      directed_item(CMD_INSERT, 32'h0000_0000);
      directed_item(CMD_INSERT, 32'hFFFF_FFFF);
      directed_item(CMD_INSERT, 32'h7FFF_FFFF);
      directed_item(CMD_SEARCH, 32'h7FFF_FFFF);
      directed_item(CMD_SEARCH, 32'h8000_0000);
      directed_item(CMD_DELETE, 32'h7FFF_FFFF);
      directed_item(CMD_SEARCH, 32'h7FFF_FFFF);
      directed_item(CMD_DELETE, 32'h8000_0000);
      directed_item(CMD_DELETE, 32'h0000_0000);
      directed_item(CMD_SEARCH, 32'h1234_5678);
      directed_item(CMD_DELETE, 32'h1234_5678);
      directed_item(CMD_SEARCH, 32'hFFFF_FFFF);
      sent = 16;
      wait_quiet();

      // Random part in segments; each segment picks a command mix and
      // whether the sender idles at all.
      seg = 0;
      while (sent < TARGET_ITEMS) begin
         seg_len = $urandom_range(30, 90);
         mix = mix_type'($urandom_range(0, 2));
         quiet = ($urandom_range(0, 3) == 0);
         pressed = (seg == 4 || seg == 14);
         if (pressed) begin
            // keep offering back to back while the receiver holds off
            mix = MIX_FILL;
            quiet = 1'b1;
            hold_offs_asked++;
         end
         while (seg_len > 0 && sent < TARGET_ITEMS) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && seg_len > 0 && sent < TARGET_ITEMS) begin
               random_item(mix);
               burst--;
               seg_len--;
               sent++;
            end
            gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               @(negedge clock);
               req_ch.valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         if (seg == 9) wait_quiet();
         seg++;
      end

      // Drop valid, drain the outstanding responses, then idle for DRAIN_CYCLES
      // so that anything stray can show up.
      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS keyed_list_insert_search_delete");
      end else begin
         $display("FAIL keyed_list_insert_search_delete");
      end
      $finish;
   end

endmodule
